/* rtl/core/sfd_pkg.sv */
// Shared types and constants for the serial frame deframer.
// No dependencies; used by serial_frame_deframer.
package sfd_pkg;

    localparam int unsigned MAX_DATA = 8;
    localparam logic [3:0]  MAX_LEN  = 4'(MAX_DATA);

    localparam logic [7:0] SYNC_BYTE  = 8'hFF;
    localparam logic [7:0] FILL_BYTE  = 8'hFF;
    localparam logic [7:0] ID_LO_RST  = 8'hFF;
    localparam logic [3:0] LEN_RST    = 4'hF;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ID_LO  = 3'd1,
        PH_HEADER = 3'd2,
        PH_DATA   = 3'd3,
        PH_CHECK  = 3'd4
    } t_phase;

endpackage

/* rtl/core/serial_frame_deframer.sv */
// Serial frame deframer: sync byte, ID, header, data and checksum parsing.
// Depends on sfd_pkg (phase type, limits and byte constants).
//
// Usage:
// - Input channel (i_valid, i_rx_byte, o_stall): one received byte per
//   transfer. A byte is taken at a clock edge with i_valid high and o_stall low.
// - Output channel (o_valid, o_frame_id, o_channel, o_length, o_payload):
//   one transfer per frame whose checksum matches; data byte i sits at
//   o_payload[8i+7:8i], bytes past o_length read 0xFF.
// - Throughput: one byte per cycle while o_stall is low. Each byte updates the parse
//   state in the cycle it is taken; the frame result is registered, so o_valid
//   is high in the cycle after the checksum byte is taken.
// - Receiver stall: the result register holds while i_stall is high. Bytes
//   keep flowing except when a checksum byte is due and the result register
//   is still occupied with i_stall high; only then o_stall is raised.
// - Reset (i_rst_n low, synchronous): parser returns to idle hunting for the
//   sync byte and the result register empties. The frame fields are cleared
//   by every byte taken in idle.
module serial_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_rx_byte,
    output logic        o_stall,
    output logic        o_valid,
    output logic [10:0] o_frame_id,
    output logic        o_channel,
    output logic [3:0]  o_length,
    output logic [63:0] o_payload,
    input  logic        i_stall
);

    sfd_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_id_lo, n_id_lo;
    logic [2:0]      r_id_hi, n_id_hi;
    logic            r_chan, n_chan;
    logic [3:0]      r_cur_len, n_cur_len;
    logic [3:0]      r_byte_count, n_byte_count;
    logic [7:0]      r_sum, n_sum;
    logic [7:0]      r_store [8];
    logic [7:0]      n_store [8];

    logic            r_out_valid, n_out_valid;
    logic [10:0]     r_out_id;
    logic            r_out_chan;
    logic [3:0]      r_out_len;
    logic [63:0]     r_out_payload;

    logic            in_xfer;
    logic            out_load;
    logic [3:0]      count_inc;
    logic [63:0]     store_flat;

    assign o_stall   = r_out_valid && i_stall && (r_phase == sfd_pkg::PH_CHECK);
    assign in_xfer   = i_valid && !o_stall;
    assign count_inc = r_byte_count + 4'd1;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            store_flat[8*i +: 8] = r_store[i];
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_id_lo      = r_id_lo;
        n_id_hi      = r_id_hi;
        n_chan       = r_chan;
        n_cur_len    = r_cur_len;
        n_byte_count = r_byte_count;
        n_sum        = r_sum;
        n_store      = r_store;
        out_load     = 1'b0;
        if (in_xfer) begin
            case (r_phase)
                sfd_pkg::PH_ID_LO: begin
                    n_id_lo = i_rx_byte;
                    n_id_hi = 3'd0;
                    n_sum   = i_rx_byte;
                    n_phase = sfd_pkg::PH_HEADER;
                end
                sfd_pkg::PH_HEADER: begin
                    n_id_hi      = i_rx_byte[7:5];
                    n_chan       = i_rx_byte[4];
                    n_cur_len    = i_rx_byte[3:0];
                    n_byte_count = 4'd0;
                    n_sum        = r_sum + i_rx_byte;
                    if (i_rx_byte[3:0] > sfd_pkg::MAX_LEN) begin
                        n_phase = sfd_pkg::PH_IDLE;
                    end else if (i_rx_byte[3:0] != 4'd0) begin
                        n_phase = sfd_pkg::PH_DATA;
                    end else begin
                        n_phase = sfd_pkg::PH_CHECK;
                    end
                end
                sfd_pkg::PH_DATA: begin
                    n_store[r_byte_count[2:0]] = i_rx_byte;
                    n_sum        = r_sum + i_rx_byte;
                    n_byte_count = count_inc;
                    if (!(r_cur_len > count_inc)) begin
                        n_phase = sfd_pkg::PH_CHECK;
                    end
                end
                sfd_pkg::PH_CHECK: begin
                    out_load = (i_rx_byte == r_sum);
                    n_phase  = sfd_pkg::PH_IDLE;
                end
                default: begin
                    n_id_lo      = sfd_pkg::ID_LO_RST;
                    n_id_hi      = 3'd0;
                    n_chan       = 1'b0;
                    n_cur_len    = sfd_pkg::LEN_RST;
                    n_byte_count = 4'd0;
                    n_sum        = 8'd0;
                    for (int i = 0; i < 8; i++) begin
                        n_store[i] = sfd_pkg::FILL_BYTE;
                    end
                    n_phase = (i_rx_byte == sfd_pkg::SYNC_BYTE) ? sfd_pkg::PH_ID_LO
                                                                : sfd_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= sfd_pkg::PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id_lo      <= n_id_lo;
        r_id_hi      <= n_id_hi;
        r_chan       <= n_chan;
        r_cur_len    <= n_cur_len;
        r_byte_count <= n_byte_count;
        r_sum        <= n_sum;
        r_store      <= n_store;
        if (out_load) begin
            r_out_id      <= {r_id_hi, r_id_lo};
            r_out_chan    <= r_chan;
            r_out_len     <= r_cur_len;
            r_out_payload <= store_flat;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_frame_id = r_out_id;
    assign o_channel  = r_out_chan;
    assign o_length   = r_out_len;
    assign o_payload  = r_out_payload;

`ifndef ASSERT_OFF
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_out_valid)
        else $error("input stalled with empty result register");

    a_result_after_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_phase) == sfd_pkg::PH_CHECK)
        else $error("result produced outside checksum phase");

    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_len <= sfd_pkg::MAX_LEN)
        else $error("result length above limit");

    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == sfd_pkg::PH_DATA |-> r_byte_count < r_cur_len)
        else $error("data byte count out of range");
`endif

endmodule
